// ===== design/nfd_pkg.sv =====
// shared types, constants and helpers for the nec ir frame decoder
package nfd_pkg;

  // frame and tick sizing
  localparam int FRAME_BITS = 32;
  localparam int TICK_WIDTH = 16;
  localparam int TICKS_W    = 16;
  localparam int COUNT_W    = 8;
  localparam int BIT_IDX_W  = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
  localparam int FRAME_EXT_W = 64;

  // mask applied to incoming tick values
  localparam logic [TICKS_W-1:0] TICK_MASK =
    (TICK_WIDTH >= TICKS_W) ? {TICKS_W{1'b1}} : TICKS_W'((64'd1 << TICK_WIDTH) - 64'd1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // configuration port sizing
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // register reset values
  localparam logic [15:0] LEADER_LOW_MIN_RST  = 16'd8500;
  localparam logic [15:0] LEADER_LOW_MAX_RST  = 16'd9500;
  localparam logic [15:0] LEADER_HIGH_MIN_RST = 16'd4000;
  localparam logic [15:0] LEADER_HIGH_MAX_RST = 16'd5000;
  localparam logic [15:0] ONE_BIT_MIN_RST     = 16'd1380;
  localparam logic [15:0] ONE_BIT_MAX_RST     = 16'd1980;
  localparam logic [7:0]  EXPECTED_RST        = 8'd67;
  localparam logic [7:0]  NOISE_LIMIT_RST     = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEADER_LOW_MIN  = 4'd0,
    CFG_LEADER_LOW_MAX  = 4'd1,
    CFG_LEADER_HIGH_MIN = 4'd2,
    CFG_LEADER_HIGH_MAX = 4'd3,
    CFG_ONE_BIT_MIN     = 4'd4,
    CFG_ONE_BIT_MAX     = 4'd5,
    CFG_EXPECTED        = 4'd6,
    CFG_NOISE_LIMIT     = 4'd7
  } cfg_idx_e;

  typedef enum logic {
    OP_EDGE    = 1'b0,
    OP_TIMEOUT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_LEADER = 2'd1,
    ST_BAD_COUNT  = 2'd2
  } status_e;

  typedef struct packed {
    logic [15:0] leader_low_min;
    logic [15:0] leader_low_max;
    logic [15:0] leader_high_min;
    logic [15:0] leader_high_max;
    logic [15:0] one_bit_min;
    logic [15:0] one_bit_max;
    logic [7:0]  expected_intervals;
    logic [7:0]  noise_limit;
  } cfg_t;

  typedef struct packed {
    logic               opcode;
    logic [TICKS_W-1:0] elapsed_ticks;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] address_byte;
    logic [7:0] address_inverse;
    logic [7:0] command_byte;
    logic [7:0] command_inverse;
  } out_item_t;

  // exclusive window check
  function automatic logic in_window(logic [TICKS_W-1:0] v, logic [15:0] lo,
                                     logic [15:0] hi);
    return (v > lo) && (v < hi);
  endfunction

endpackage

// ===== design/nfd_cfg_regs.sv =====
// configuration register file with index decode
module nfd_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [nfd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [nfd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output nfd_pkg::cfg_t                  cfg_o
);
  import nfd_pkg::*;

  cfg_t cfg_q;

  // writes are always taken
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_low_min     <= LEADER_LOW_MIN_RST;
      cfg_q.leader_low_max     <= LEADER_LOW_MAX_RST;
      cfg_q.leader_high_min    <= LEADER_HIGH_MIN_RST;
      cfg_q.leader_high_max    <= LEADER_HIGH_MAX_RST;
      cfg_q.one_bit_min        <= ONE_BIT_MIN_RST;
      cfg_q.one_bit_max        <= ONE_BIT_MAX_RST;
      cfg_q.expected_intervals <= EXPECTED_RST;
      cfg_q.noise_limit        <= NOISE_LIMIT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LEADER_LOW_MIN:  cfg_q.leader_low_min     <= cfg_data_i[15:0];
        CFG_LEADER_LOW_MAX:  cfg_q.leader_low_max     <= cfg_data_i[15:0];
        CFG_LEADER_HIGH_MIN: cfg_q.leader_high_min    <= cfg_data_i[15:0];
        CFG_LEADER_HIGH_MAX: cfg_q.leader_high_max    <= cfg_data_i[15:0];
        CFG_ONE_BIT_MIN:     cfg_q.one_bit_min        <= cfg_data_i[15:0];
        CFG_ONE_BIT_MAX:     cfg_q.one_bit_max        <= cfg_data_i[15:0];
        CFG_EXPECTED:        cfg_q.expected_intervals <= cfg_data_i[7:0];
        CFG_NOISE_LIMIT:     cfg_q.noise_limit        <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/nfd_frame_engine.sv =====
// frame state, interval decode and result register
module nfd_frame_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nfd_pkg::cfg_t       cfg_i,
  input  logic                step_i,
  input  nfd_pkg::in_item_t   item_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output nfd_pkg::out_item_t  out_data_o
);
  import nfd_pkg::*;

  logic                  active_q, active_d;
  logic [COUNT_W-1:0]    count_q, count_d;
  logic                  lead_q, lead_d;
  logic [FRAME_BITS-1:0] shift_q, shift_d;
  logic [FRAME_BITS-1:0] last_q, last_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;

  logic [TICKS_W-1:0]     ticks;
  logic [COUNT_W-1:0]     bit_off;
  logic [COUNT_W-2:0]     bit_j;
  logic                   emit;
  status_e                status;
  logic [FRAME_EXT_W-1:0] frame_ext;

  // result register frees up when empty or being drained
  assign ready_o     = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign ticks   = item_i.elapsed_ticks & TICK_MASK;
  assign bit_off = count_q - COUNT_W'(3);
  assign bit_j   = bit_off[COUNT_W-1:1];

  // frame status at timeout, leader check first
  always_comb begin
    priority if (!(lead_q && (count_q >= COUNT_W'(2)))) begin
      status = ST_BAD_LEADER;
    end else if (count_q != cfg_i.expected_intervals) begin
      status = ST_BAD_COUNT;
    end else begin
      status = ST_OK;
    end
  end

  // next state for one step
  always_comb begin
    active_d    = active_q;
    count_d     = count_q;
    lead_d      = lead_q;
    shift_d     = shift_q;
    last_d      = last_q;
    emit        = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    if (step_i) begin
      if (item_i.opcode == OP_EDGE) begin
        if (!active_q) begin
          active_d = 1'b1;
          count_d  = '0;
          lead_d   = 1'b0;
          shift_d  = '0;
        end else if (count_q != COUNT_MAX) begin
          if (count_q == COUNT_W'(0)) begin
            lead_d = in_window(ticks, cfg_i.leader_low_min, cfg_i.leader_low_max);
          end else if (count_q == COUNT_W'(1)) begin
            lead_d = lead_q &&
                     in_window(ticks, cfg_i.leader_high_min, cfg_i.leader_high_max);
          end else if ((count_q >= COUNT_W'(3)) && count_q[0] &&
                       ({1'b0, bit_j} < COUNT_W'(FRAME_BITS)) &&
                       in_window(ticks, cfg_i.one_bit_min, cfg_i.one_bit_max)) begin
            shift_d[bit_j[BIT_IDX_W-1:0]] = 1'b1;
          end
          count_d = count_q + COUNT_W'(1);
        end
      end else if (active_q) begin
        active_d = 1'b0;
        count_d  = '0;
        lead_d   = 1'b0;
        shift_d  = '0;
        if (count_q > cfg_i.noise_limit) begin
          emit = 1'b1;
          if (status == ST_OK) begin
            last_d = shift_q;
          end
        end
      end
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  // result payload from the last good frame
  assign frame_ext = FRAME_EXT_W'(last_d);
  always_comb begin
    out_d                 = out_q;
    if (emit) begin
      out_d.status          = status;
      out_d.address_byte    = frame_ext[7:0];
      out_d.address_inverse = frame_ext[15:8];
      out_d.command_byte    = frame_ext[23:16];
      out_d.command_inverse = frame_ext[31:24];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      count_q     <= '0;
      lead_q      <= 1'b0;
      shift_q     <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      count_q     <= count_d;
      lead_q      <= lead_d;
      shift_q     <= shift_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

// ===== design/nec_ir_frame_decoder_core.sv =====
// nec ir frame decoder top level: input register, config and frame engine
// a result passes the input register and then the result register after the timeout transfer is accepted
// throughput: one item per cycle while the result is not stalled, set by the single-pass frame engine step
// a stalled result holds the engine, and the input register then holds one item
// reset: asynchronous active low, clears frame state, last frame and both valid
// flags, and loads the default timing windows and counts
module nec_ir_frame_decoder_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  nfd_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output nfd_pkg::out_item_t             out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [nfd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [nfd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import nfd_pkg::*;

  cfg_t     cfg;
  logic     in_valid_q;
  in_item_t in_q;
  logic     eng_ready;
  logic     step;
  logic     in_take;

  // input register handshake
  assign step       = in_valid_q && eng_ready;
  assign in_stall_o = in_valid_q && !eng_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  // input payload register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  // configuration registers
  nfd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // frame decode and result register
  nfd_frame_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (step),
    .item_i      (in_q),
    .ready_o     (eng_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for the nec ir frame decoder core: directed and random event streams
`timescale 1ns / 100ps

module tb_top;
  import nfd_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RST_CYCLES   = 4;
  localparam int DRAIN_CYCLES = 8;
  localparam longint RUN_LIMIT_NS = 64'd12_000_000;
  // register indexes past the last defined one are ignored by the block
  localparam int CFG_IDX_SPARE = int'(CFG_NOISE_LIMIT) + 1;
  localparam int CFG_IDX_TOP   = (1 << CFG_IDX_W) - 1;

  typedef enum int {GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH} gap_mode_e;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // decoder model state
  cfg_t                  timing_cfg;
  logic                  frame_open = 1'b0;
  logic [COUNT_W-1:0]    edge_count = '0;
  logic                  leader_good = 1'b0;
  logic [FRAME_BITS-1:0] bits_acc = '0;
  logic [FRAME_BITS-1:0] last_good_bits = '0;

  in_item_t    item_q[$];
  out_item_t   report_q[$];
  out_item_t   next_report;
  int unsigned queued_total = 0;
  int unsigned accepted_total = 0;
  int unsigned mismatch_count = 0;
  gap_mode_e   gap_mode = GAP_NONE;

  nec_ir_frame_decoder_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  function automatic bit in_open_range(logic [15:0] v, logic [15:0] lo, logic [15:0] hi);
    return (v > lo) && (v < hi);
  endfunction

  // advance the decoder model by one accepted event
  task automatic decode_event(input in_item_t ev);
    logic [15:0]        tk;
    logic [COUNT_W-1:0] n;
    logic               lead;
    out_item_t          rep;
    int                 j;
    tk = ev.elapsed_ticks & TICK_MASK;
    if (op_e'(ev.opcode) == OP_EDGE) begin
      if (!frame_open) begin
        // first edge opens a frame and carries no interval
        frame_open  = 1'b1;
        edge_count  = '0;
        leader_good = 1'b0;
        bits_acc    = '0;
      end else if (edge_count != COUNT_MAX) begin
        if (edge_count == 0) begin
          leader_good = in_open_range(tk, timing_cfg.leader_low_min,
                                      timing_cfg.leader_low_max);
        end else if (edge_count == 1) begin
          leader_good = leader_good && in_open_range(tk, timing_cfg.leader_high_min,
                                                     timing_cfg.leader_high_max);
        end else if (edge_count >= 3 && edge_count[0]) begin
          j = int'(edge_count - 8'd3) >> 1;
          if (j < FRAME_BITS && in_open_range(tk, timing_cfg.one_bit_min,
                                              timing_cfg.one_bit_max)) begin
            bits_acc[j] = 1'b1;
          end
        end
        edge_count = edge_count + 1'b1;
      end
    end else if (frame_open) begin
      n           = edge_count;
      lead        = leader_good && (n >= 2);
      frame_open  = 1'b0;
      edge_count  = '0;
      leader_good = 1'b0;
      // short frames are noise and report nothing
      if (n > timing_cfg.noise_limit) begin
        if (!lead) begin
          rep.status = ST_BAD_LEADER;
        end else if (n != timing_cfg.expected_intervals) begin
          rep.status = ST_BAD_COUNT;
        end else begin
          rep.status     = ST_OK;
          last_good_bits = bits_acc;
        end
        rep.address_byte    = last_good_bits[7:0];
        rep.address_inverse = last_good_bits[15:8];
        rep.command_byte    = last_good_bits[23:16];
        rep.command_inverse = last_good_bits[31:24];
        report_q.push_back(rep);
      end
      bits_acc = '0;
    end
  endtask

  function automatic bit sender_pauses();
    case (gap_mode)
      GAP_SEND: return $urandom_range(0, 99) < 84;
      GAP_BOTH: return $urandom_range(0, 99) < 25;
      default:  return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (gap_mode)
      GAP_RECV: return $urandom_range(0, 99) < 84;
      GAP_BOTH: return $urandom_range(0, 99) < 25;
      default:  return 1'b0;
    endcase
  endfunction

  // event driver: holds a stalled transfer, otherwise offers the next pending event
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        decode_event(in_data);
        accepted_total++;
      end
      if (!in_valid || !in_stall) begin
        if (item_q.size() != 0 && !sender_pauses()) begin
          in_data  <= item_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // report monitor: compares each result transfer with the oldest predicted report
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (report_q.size() == 0) begin
          $error("result transfer with no report pending: status %0d", out_data.status);
          mismatch_count++;
        end else begin
          next_report = report_q.pop_front();
          check_field("status", next_report.status, out_data.status);
          check_field("address_byte", next_report.address_byte, out_data.address_byte);
          check_field("address_inverse", next_report.address_inverse,
                      out_data.address_inverse);
          check_field("command_byte", next_report.command_byte, out_data.command_byte);
          check_field("command_inverse", next_report.command_inverse,
                      out_data.command_inverse);
        end
      end
      out_stall <= receiver_stalls();
    end
  end

  // one register write transfer, mirrored into the model on the handshake
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_LEADER_LOW_MIN:  timing_cfg.leader_low_min     = data;
      CFG_LEADER_LOW_MAX:  timing_cfg.leader_low_max     = data;
      CFG_LEADER_HIGH_MIN: timing_cfg.leader_high_min    = data;
      CFG_LEADER_HIGH_MAX: timing_cfg.leader_high_max    = data;
      CFG_ONE_BIT_MIN:     timing_cfg.one_bit_min        = data;
      CFG_ONE_BIT_MAX:     timing_cfg.one_bit_max        = data;
      CFG_EXPECTED:        timing_cfg.expected_intervals = data[7:0];
      CFG_NOISE_LIMIT:     timing_cfg.noise_limit        = data[7:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // 8-bit registers get random upper data bits, which the block must drop
  task automatic write_all_regs(input cfg_t c);
    write_reg(CFG_LEADER_LOW_MIN, c.leader_low_min);
    write_reg(CFG_LEADER_LOW_MAX, c.leader_low_max);
    write_reg(CFG_LEADER_HIGH_MIN, c.leader_high_min);
    write_reg(CFG_LEADER_HIGH_MAX, c.leader_high_max);
    write_reg(CFG_ONE_BIT_MIN, c.one_bit_min);
    write_reg(CFG_ONE_BIT_MAX, c.one_bit_max);
    write_reg(CFG_EXPECTED, {8'($urandom), c.expected_intervals});
    write_reg(CFG_NOISE_LIMIT, {8'($urandom), c.noise_limit});
  endtask

  function automatic void rand_window(output logic [15:0] lo, output logic [15:0] hi);
    int l;
    int h;
    case ($urandom_range(0, 7))
      0: begin
        // any pair, possibly empty or inverted
        l = $urandom_range(0, 65535);
        h = $urandom_range(0, 65535);
      end
      1: begin
        l = 0;
        h = 65535;
      end
      default: begin
        l = $urandom_range(0, 60000);
        h = l + $urandom_range(2, 3000);
      end
    endcase
    lo = 16'(l);
    hi = 16'(h);
  endfunction

  task automatic set_random_config();
    cfg_t c;
    int   e;
    if ($urandom_range(0, 2) == 0) begin
      write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_SPARE, CFG_IDX_TOP)), 16'($urandom));
    end
    rand_window(c.leader_low_min, c.leader_low_max);
    rand_window(c.leader_high_min, c.leader_high_max);
    rand_window(c.one_bit_min, c.one_bit_max);
    e = $urandom_range(2, 40);
    c.expected_intervals = 8'(e);
    c.noise_limit = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, e - 1));
    write_all_regs(c);
  endtask

  function automatic void push_item(op_e op, logic [15:0] tk);
    in_item_t it;
    it.opcode        = op;
    it.elapsed_ticks = tk;
    item_q.push_back(it);
    queued_total++;
  endfunction

  // interval value inside or outside an exclusive window
  function automatic logic [15:0] pick_ticks(logic [15:0] lo, logic [15:0] hi, bit want_in);
    int l;
    int h;
    l = lo;
    h = hi;
    if (want_in && h > l + 1) return 16'($urandom_range(l + 1, h - 1));
    case ($urandom_range(0, 9))
      0, 1:    return lo;
      2, 3:    return hi;
      4, 5:    return 16'($urandom_range(0, l));
      6, 7:    return 16'($urandom_range(h, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int pick_length();
    int e;
    int nl;
    int r;
    e  = timing_cfg.expected_intervals;
    nl = timing_cfg.noise_limit;
    r  = $urandom_range(0, 99);
    if (r < 60) return e;
    if (r < 70) return (e > 0) ? e - 1 : 0;
    if (r < 80) return e + 1;
    if (r < 88) return $urandom_range(0, nl);
    return $urandom_range(0, 80);
  endfunction

  // start edge, n intervals shaped by the current windows, closing timeout
  function automatic int queue_frame(int n, bit good_leader);
    logic [15:0] tk;
    push_item(OP_EDGE, 16'($urandom));
    for (int i = 0; i < n; i++) begin
      if (i == 0) begin
        tk = pick_ticks(timing_cfg.leader_low_min, timing_cfg.leader_low_max,
                        good_leader || $urandom_range(0, 1));
      end else if (i == 1) begin
        tk = pick_ticks(timing_cfg.leader_high_min, timing_cfg.leader_high_max,
                        good_leader || $urandom_range(0, 1));
      end else if (i >= 3 && i % 2 == 1) begin
        tk = pick_ticks(timing_cfg.one_bit_min, timing_cfg.one_bit_max, $urandom_range(0, 1));
      end else begin
        tk = $urandom_range(0, 1) ? 16'($urandom_range(400, 700)) : 16'($urandom);
      end
      push_item(OP_EDGE, tk);
    end
    push_item(OP_TIMEOUT, 16'($urandom));
    return n + 2;
  endfunction

  task automatic run_random_phase(int budget);
    int sent;
    sent = 0;
    while (sent < budget) begin
      // stray timeout while idle
      if ($urandom_range(0, 9) == 0) push_item(OP_TIMEOUT, 16'($urandom));
      sent += queue_frame(pick_length(), $urandom_range(0, 99) < 85);
    end
  endtask

  // wait until every event is taken and every report has come back
  task automatic settle();
    while (accepted_total != queued_total || report_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    cfg_t c;
    timing_cfg = {LEADER_LOW_MIN_RST, LEADER_LOW_MAX_RST, LEADER_HIGH_MIN_RST,
                  LEADER_HIGH_MAX_RST, ONE_BIT_MIN_RST, ONE_BIT_MAX_RST,
                  EXPECTED_RST, NOISE_LIMIT_RST};
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames on a five-interval frame with no noise filtering
    write_reg(CFG_EXPECTED, 16'd5);
    write_reg(CFG_NOISE_LIMIT, 16'd0);
    // timeout while idle is ignored
    push_item(OP_TIMEOUT, 16'hFFFF);
    // one interval with a bad leader, before any good frame: zero bytes
    push_item(OP_EDGE, 16'hFFFF);
    push_item(OP_EDGE, 16'd0);
    push_item(OP_TIMEOUT, 16'd0);
    // good leader and a one in bit 0, but four intervals: wrong count, bits not kept
    push_item(OP_EDGE, 16'd0);
    push_item(OP_EDGE, 16'd9000);
    push_item(OP_EDGE, 16'd4500);
    push_item(OP_EDGE, 16'd560);
    push_item(OP_EDGE, 16'd1690);
    push_item(OP_TIMEOUT, 16'd0);
    // bad leader and wrong count: leader wins, bytes from the last good frame
    push_item(OP_EDGE, 16'd0);
    push_item(OP_EDGE, 16'hFFFF);
    push_item(OP_EDGE, 16'd4500);
    push_item(OP_EDGE, 16'd560);
    push_item(OP_TIMEOUT, 16'hFFFF);
    // good leader, wrong count
    push_item(OP_EDGE, 16'd0);
    push_item(OP_EDGE, 16'd9000);
    push_item(OP_EDGE, 16'd4500);
    push_item(OP_TIMEOUT, 16'd0);
    // noise frame, dropped
    push_item(OP_EDGE, 16'd0);
    push_item(OP_TIMEOUT, 16'd0);
    settle();

    // mostly full length frames at the power-on settings, no idling
    c = {LEADER_LOW_MIN_RST, LEADER_LOW_MAX_RST, LEADER_HIGH_MIN_RST, LEADER_HIGH_MAX_RST,
         ONE_BIT_MIN_RST, ONE_BIT_MAX_RST, EXPECTED_RST, NOISE_LIMIT_RST};
    write_all_regs(c);
    run_random_phase(150);
    settle();

    // random settings under each idling pattern
    for (int p = 0; p < 8; p++) begin
      gap_mode = gap_mode_e'(p % 4);
      set_random_config();
      run_random_phase(70);
      settle();
    end

    // all registers zero: every window empty
    gap_mode = GAP_SEND;
    write_all_regs('0);
    run_random_phase(40);
    settle();

    // widest windows, counts at the top: saturating frames and bits past the frame
    gap_mode = GAP_BOTH;
    c = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 8'd255, 8'd254};
    write_all_regs(c);
    void'(queue_frame(254, 1'b1));
    void'(queue_frame($urandom_range(255, 300), 1'b1));
    settle();

    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
